@@ sv/spt_pkg.sv @@
// ---------------------------------------------------------------------------
// spt_pkg
// Shared types and constants for the sparse penalty threshold block.
// ---------------------------------------------------------------------------
package spt_pkg;

   localparam int DATA_WIDTH_DEF  = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int REG_INDEX_WIDTH = 2;

   // Sideband bits that ride along with the divider: bad flag, sign, divide select.
   localparam int TAG_EXTRA = 3;

   typedef enum logic [1:0] {
      MODE_PASS  = 2'd0,
      MODE_LASSO = 2'd1,
      MODE_SCAD  = 2'd2,
      MODE_MCP   = 2'd3
   } mode_type;

   typedef logic [REG_INDEX_WIDTH-1:0] reg_index_type;

   localparam reg_index_type REG_MODE   = 2'd0;
   localparam reg_index_type REG_NONNEG = 2'd1;
   localparam reg_index_type REG_LAMBDA = 2'd2;
   localparam reg_index_type REG_GAMMA  = 2'd3;

endpackage

@@ sv/spt_div.sv @@
// ---------------------------------------------------------------------------
// spt_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// tag that travels with each request. Bubbles collapse under a stall.
// ---------------------------------------------------------------------------
module spt_div #(
   parameter int DATA_WIDTH = spt_pkg::DATA_WIDTH_DEF,
   parameter int TAG_WIDTH  = spt_pkg::DATA_WIDTH_DEF + spt_pkg::TAG_EXTRA
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_stall,
   input  logic [2*DATA_WIDTH-2:0]   in_num,
   input  logic [DATA_WIDTH-2:0]     in_den,
   input  logic [TAG_WIDTH-1:0]      in_tag,
   output logic                      out_valid,
   input  logic                      out_stall,
   output logic [DATA_WIDTH-1:0]     out_quo,
   output logic [TAG_WIDTH-1:0]      out_tag
);
   import spt_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int PW = 2*DATA_WIDTH - 1;

   // The caller guarantees the quotient fits in W bits, so the upper
   // numerator bits start out below the divisor.
   logic [W-2:0]           rem_ff  [0:W];
   logic [W-1:0]           quo_ff  [0:W];
   logic [W-2:0]           den_ff  [0:W];
   logic [TAG_WIDTH-1:0]   tag_ff  [0:W];
   logic [W:0]             vld_ff;
   logic [W:0]             stage_en;
   logic [W-2:0]           rem_in  [1:W];
   logic [W-1:0]           quo_in  [1:W];

   assign stage_en[W] = !vld_ff[W] || !out_stall;
   assign in_stall    = !stage_en[0];
   assign out_valid   = vld_ff[W];
   assign out_quo     = quo_ff[W];
   assign out_tag     = tag_ff[W];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (stage_en[0]) begin
         vld_ff[0] <= in_valid;
      end
      if (stage_en[0]) begin
         rem_ff[0] <= in_num[PW-1:W];
         quo_ff[0] <= in_num[W-1:0];
         den_ff[0] <= in_den;
         tag_ff[0] <= in_tag;
      end
   end

   for (genvar k = 0; k < W; k++) begin : g_step
      logic [W-1:0] trial;
      logic [W-1:0] diff;
      logic         fits;

      assign stage_en[k] = !vld_ff[k] || stage_en[k+1];
      assign trial       = {rem_ff[k], quo_ff[k][W-1]};
      assign diff        = trial - {1'b0, den_ff[k]};
      assign fits        = trial >= {1'b0, den_ff[k]};
      assign rem_in[k+1] = fits ? diff[W-2:0] : trial[W-2:0];
      assign quo_in[k+1] = {quo_ff[k][W-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (stage_en[k+1]) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         if (stage_en[k+1]) begin
            rem_ff[k+1] <= rem_in[k+1];
            quo_ff[k+1] <= quo_in[k+1];
            den_ff[k+1] <= den_ff[k];
            tag_ff[k+1] <= tag_ff[k];
         end
      end
   end

endmodule

@@ sv/sparse_penalty_threshold.sv @@
// ---------------------------------------------------------------------------
// sparse_penalty_threshold
// Element-wise penalized shrinkage of a signed fixed-point sample under a
// pass-through, lasso, SCAD or MCP penalty, with a non-negative variant.
// ---------------------------------------------------------------------------
//
//   port group | direction | content
//   -----------+-----------+-------------------------------------------------
//   req_       | in        | sample, valid/stall
//   rsp_       | out       | shrunk sample and bad-setting flag, valid/stall
//   csr_       | in        | register write: enable, index, data
//
// One request enters per cycle while no stall holds the flow; a result passes the
// input, threshold, product, one-bit-per-stage divider and output stages in order.
// Reset clears the valid bits of every stage and loads the register defaults.
// A stall at the result side is absorbed by empty stages first; the input
// stalls only once every stage between it and the output holds a request.
//
module sparse_penalty_threshold #(
   parameter int DATA_WIDTH = spt_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = spt_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [DATA_WIDTH-1:0]  req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [DATA_WIDTH-1:0]  rsp_shrunk,
   output logic                          rsp_bad_setting,
   input  logic                          csr_wen,
   input  spt_pkg::reg_index_type        csr_index,
   input  logic [DATA_WIDTH-2:0]         csr_wdata
);
   import spt_pkg::*;

   localparam int W         = DATA_WIDTH;
   localparam int PW        = 2*DATA_WIDTH - 1;
   localparam int TAG_WIDTH = DATA_WIDTH + TAG_EXTRA;

   localparam logic [W-1:0] ONE_Q       = W'(64'd1 << FRAC_BITS);
   localparam logic [W-1:0] TWO_Q       = W'(64'd2 << FRAC_BITS);
   localparam logic [W-2:0] GAMMA_RESET = (W-1)'(64'd3 << FRAC_BITS);
   localparam logic [W-1:0] HALF_RANGE  = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MAX_POS     = {1'b0, {(W-1){1'b1}}};

   // Configuration registers.
   mode_type      mode_ff;
   logic          nonneg_ff;
   logic [W-2:0]  lambda_ff;
   logic [W-2:0]  gamma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_PASS;
         nonneg_ff <= 1'b0;
         lambda_ff <= '0;
         gamma_ff  <= GAMMA_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            REG_MODE:   mode_ff   <= mode_type'(csr_wdata[1:0]);
            REG_NONNEG: nonneg_ff <= csr_wdata[0];
            REG_LAMBDA: lambda_ff <= csr_wdata;
            REG_GAMMA:  gamma_ff  <= csr_wdata;
            default:    mode_ff   <= mode_ff;
         endcase
      end
   end

   // Stage enables; a stage loads when it is empty or its content moves on.
   logic s0_en, s1_en, s2_en;
   logic div_in_stall;

   // Stage 0: input register.
   logic          s0_valid_ff;
   logic [W-1:0]  s0_sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_en) begin
         s0_valid_ff <= req_valid;
      end
      if (s0_en) begin
         s0_sample_ff <= req_sample;
      end
   end

   // Stage 1: magnitude, soft threshold, gamma checks and multiplier operands.
   logic          s1_neg_in, s1_bad_in, s1_zero_in, s1_above2l_in;
   logic [W-1:0]  s1_mag_in, s1_soft_in, s1_mul_y_in;
   logic [W-2:0]  s1_mul_x_in, s1_den_in;
   logic [W-1:0]  lambda_ext, gamma_ext;
   logic [W-2:0]  gamma_m1, gamma_m2;
   logic          is_scad;

   always_comb begin
      lambda_ext    = {1'b0, lambda_ff};
      gamma_ext     = {1'b0, gamma_ff};
      gamma_m1      = (W-1)'(gamma_ext - ONE_Q);
      gamma_m2      = (W-1)'(gamma_ext - TWO_Q);
      is_scad       = (mode_ff == MODE_SCAD);
      s1_neg_in     = s0_sample_ff[W-1];
      s1_mag_in     = s1_neg_in ? (~s0_sample_ff + 1'b1) : s0_sample_ff;
      s1_soft_in    = (s1_mag_in > lambda_ext) ? (s1_mag_in - lambda_ext) : '0;
      s1_above2l_in = s1_mag_in > {lambda_ff, 1'b0};
      s1_bad_in     = (is_scad && (gamma_ext <= TWO_Q))
                   || ((mode_ff == MODE_MCP) && (gamma_ext <= ONE_Q));
      s1_zero_in    = s1_bad_in || (s1_neg_in && nonneg_ff);
      // SCAD needs (gamma-1)*a, MCP needs gamma*soft; one multiplier serves both.
      s1_mul_x_in   = is_scad ? gamma_m1 : gamma_ff;
      s1_mul_y_in   = is_scad ? s1_mag_in : s1_soft_in;
      s1_den_in     = is_scad ? gamma_m2 : gamma_m1;
   end

   logic          s1_valid_ff, s1_neg_ff, s1_bad_ff, s1_zero_ff, s1_above2l_ff;
   mode_type      s1_mode_ff;
   logic [W-1:0]  s1_mag_ff, s1_soft_ff, s1_mul_y_ff;
   logic [W-2:0]  s1_mul_x_ff, s1_den_ff, s1_lambda_ff, s1_gamma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= s0_valid_ff;
      end
      if (s1_en) begin
         s1_neg_ff     <= s1_neg_in;
         s1_bad_ff     <= s1_bad_in;
         s1_zero_ff    <= s1_zero_in;
         s1_above2l_ff <= s1_above2l_in;
         s1_mode_ff    <= mode_ff;
         s1_mag_ff     <= s1_mag_in;
         s1_soft_ff    <= s1_soft_in;
         s1_mul_x_ff   <= s1_mul_x_in;
         s1_mul_y_ff   <= s1_mul_y_in;
         s1_den_ff     <= s1_den_in;
         s1_lambda_ff  <= lambda_ff;
         s1_gamma_ff   <= gamma_ff;
      end
   end

   // Stage 2: products.
   logic [PW-1:0] s2_gl_in, s2_px_in;

   assign s2_gl_in = PW'(s1_lambda_ff) * PW'(s1_gamma_ff);
   assign s2_px_in = PW'(s1_mul_x_ff) * PW'(s1_mul_y_ff);

   logic          s2_valid_ff, s2_neg_ff, s2_bad_ff, s2_zero_ff, s2_above2l_ff;
   mode_type      s2_mode_ff;
   logic [W-1:0]  s2_mag_ff, s2_soft_ff;
   logic [W-2:0]  s2_den_ff;
   logic [PW-1:0] s2_gl_ff, s2_px_ff;

   assign s2_en     = !s2_valid_ff || !div_in_stall;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign s0_en     = !s0_valid_ff || s1_en;
   assign req_stall = !s0_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_en) begin
         s2_neg_ff     <= s1_neg_ff;
         s2_bad_ff     <= s1_bad_ff;
         s2_zero_ff    <= s1_zero_ff;
         s2_above2l_ff <= s1_above2l_ff;
         s2_mode_ff    <= s1_mode_ff;
         s2_mag_ff     <= s1_mag_ff;
         s2_soft_ff    <= s1_soft_ff;
         s2_den_ff     <= s1_den_ff;
         s2_gl_ff      <= s2_gl_in;
         s2_px_ff      <= s2_px_in;
      end
   end

   // Region select and divider numerator. The magnitude is compared with
   // gamma*lambda at the product's doubled fraction precision.
   logic          above_gl, use_div;
   logic [W-1:0]  pre_mag;
   logic [PW-1:0] div_num;
   logic [TAG_WIDTH-1:0] div_tag;

   always_comb begin
      above_gl = (PW'(s2_mag_ff) << FRAC_BITS) > s2_gl_ff;
      div_num  = (s2_mode_ff == MODE_SCAD) ? (s2_px_ff - s2_gl_ff) : s2_px_ff;
      use_div  = 1'b0;
      pre_mag  = '0;
      if (!s2_zero_ff) begin
         case (s2_mode_ff)
            MODE_PASS:  pre_mag = s2_mag_ff;
            MODE_LASSO: pre_mag = s2_soft_ff;
            MODE_SCAD: begin
               if (above_gl) begin
                  pre_mag = s2_mag_ff;
               end else if (s2_above2l_ff) begin
                  use_div = 1'b1;
               end else begin
                  pre_mag = s2_soft_ff;
               end
            end
            MODE_MCP: begin
               if (above_gl) begin
                  pre_mag = s2_mag_ff;
               end else begin
                  use_div = 1'b1;
               end
            end
            default: pre_mag = s2_mag_ff;
         endcase
      end
      div_tag = {s2_bad_ff, s2_neg_ff, use_div, pre_mag};
   end

   logic                 div_out_valid, div_out_stall;
   logic [W-1:0]         div_quo;
   logic [TAG_WIDTH-1:0] div_out_tag;

   spt_div #(
      .DATA_WIDTH (DATA_WIDTH),
      .TAG_WIDTH  (TAG_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_stall  (div_in_stall),
      .in_num    (div_num),
      .in_den    (s2_den_ff),
      .in_tag    (div_tag),
      .out_valid (div_out_valid),
      .out_stall (div_out_stall),
      .out_quo   (div_quo),
      .out_tag   (div_out_tag)
   );

   // Output stage: pick the magnitude, restore the sign, clamp to range.
   logic          fin_bad, fin_neg, fin_use_div;
   logic [W-1:0]  fin_mag;
   logic [W-1:0]  rsp_shrunk_in;
   logic          rsp_en;
   logic          rsp_valid_ff, rsp_bad_ff;
   logic [W-1:0]  rsp_shrunk_ff;

   always_comb begin
      fin_bad     = div_out_tag[W+2];
      fin_neg     = div_out_tag[W+1];
      fin_use_div = div_out_tag[W];
      fin_mag     = fin_use_div ? div_quo : div_out_tag[W-1:0];
      if (fin_neg) begin
         if (fin_mag > HALF_RANGE) begin
            fin_mag = HALF_RANGE;
         end
         rsp_shrunk_in = ~fin_mag + 1'b1;
      end else begin
         if (fin_mag > MAX_POS) begin
            fin_mag = MAX_POS;
         end
         rsp_shrunk_in = fin_mag;
      end
   end

   assign rsp_en        = !rsp_valid_ff || !rsp_stall;
   assign div_out_stall = !rsp_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_en) begin
         rsp_valid_ff <= div_out_valid;
      end
      if (rsp_en) begin
         rsp_shrunk_ff <= rsp_shrunk_in;
         rsp_bad_ff    <= fin_bad;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_shrunk      = rsp_shrunk_ff;
   assign rsp_bad_setting = rsp_bad_ff;

endmodule
